/* rtl/position_histogram_normalizer_macros.svh */
// Assertion macros for the position histogram normalizer checker.
// No dependencies; every macro expects clk and arst_n in the scope where it is used.
`ifndef POSITION_HISTOGRAM_NORMALIZER_MACROS_SVH
`define POSITION_HISTOGRAM_NORMALIZER_MACROS_SVH

// same-cycle implication, idle during reset
`define PHN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle during reset
`define PHN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/phn_pkg.sv */
// Shared types and constants for the position histogram normalizer.
// No dependencies; used by every module of the block except phn_ram.
`default_nettype none

package phn_pkg;

	localparam int NUM_BINS_DEF = 64;

	// field widths
	localparam int POS_W      = 32;
	localparam int CORPUS_W   = 31;
	localparam int YR_W       = 17;
	localparam int CNT_W      = 32;
	localparam int BIN_OUT_W  = 6;
	localparam int S_DATA_W   = 32;
	localparam int M_DATA_W   = 104;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;
	localparam logic [CFG_IDX_W-1:0] CFG_CORPUS_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_RANGE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE   = 2'd2;

	localparam logic [CORPUS_W-1:0] CORPUS_RST = 31'd1;
	localparam logic [YR_W-1:0]     Y_RANGE_RST = 17'd256;

	// item kinds on s_tuser
	localparam logic KIND_HIT    = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// shared divider
	localparam int DIV_NUM_W  = 50;
	localparam int DIV_Q_W    = 17;
	localparam int DIV_STEP_W = 5;
	localparam logic [DIV_STEP_W-1:0] SCALE_STEPS = 5'd17;

	typedef struct packed {
		logic                  start;
		logic [DIV_STEP_W-1:0] steps;
	} div_req_t;

	// one bin entry in the store
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] first;
	} bin_entry_t;

	localparam int ENTRY_W = $bits(bin_entry_t);

endpackage

`default_nettype wire

/* rtl/phn_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module phn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/phn_div.sv */
// Restoring divider, one quotient bit per cycle, shared by bin mapping and scaling.
// Depends on phn_pkg. Caller pre-shifts the divisor by steps-1 and guarantees
// the quotient fits in steps bits.
`default_nettype none

module phn_div
	import phn_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire div_req_t             req,
	input  wire logic [DIV_NUM_W-1:0] num,
	input  wire logic [DIV_NUM_W-1:0] den_sh,
	output logic                      done,
	output logic      [DIV_Q_W-1:0]   quot
);

	logic [DIV_NUM_W-1:0]  rem_q;
	logic [DIV_NUM_W-1:0]  dsh_q;
	logic [DIV_Q_W-1:0]    quot_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic                  done_q;
	logic                  ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.steps;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_STEP_W'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= num;
			dsh_q  <= den_sh;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[DIV_Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

/* rtl/position_histogram_normalizer.sv */
// Top level of the position histogram normalizer: sequencer, bin store and output register.
// Depends on phn_pkg, phn_ram and phn_div.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------------------
//  s       | in  | s_tvalid / s_tready     | s_tuser = kind, s_tdata = position
//  m       | out | m_tvalid / m_tready     | m_tdata = bin result fields, m_tlast = last
//  cfg     | in  | cfg_we (no back-pressure)| cfg_index, cfg_data
//
// One transaction at a time. For a hit the shared divider first maps the position to a
// bin, one bin-index bit per cycle, then the bin store is read and written back.
// Negative positions only advance the hit index; positions beyond the corpus skip the divider.
// A finish runs a peak sweep over the store, then reads and reports each bin in turn:
// the raw count, or when normalizing a registered product and 17 divider steps per bin.
// Reset clears the per-bin valid flags at once; no clearing pass is needed.
// A stalled m_tready holds the current result; nothing else moves meanwhile.
`default_nettype none

module position_histogram_normalizer
	import phn_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// hit / finish input
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,   // [31:0] position
	input  wire logic                  s_tuser,   // [0] kind
	// bin results
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [M_DATA_W-1:0]   m_tdata,   // [5:0] bin_index, [37:6] bin_value,
	                                              // [69:38] first_hit, [70] first_valid,
	                                              // [102:71] peak_count, [103] zero
	output logic                       m_tlast,   // last
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;  // waiting for a transaction
	localparam logic [3:0] ST_BDIV = 4'd1;  // bin mapping in the divider
	localparam logic [3:0] ST_BRD  = 4'd2;  // store read of the hit bin
	localparam logic [3:0] ST_BUPD = 4'd3;  // write back count / first index
	localparam logic [3:0] ST_PEAK = 4'd4;  // peak sweep over the store
	localparam logic [3:0] ST_ERD  = 4'd5;  // store read of the bin to report
	localparam logic [3:0] ST_EVAL = 4'd6;  // entry in hand, raw or start scaling
	localparam logic [3:0] ST_EMUL = 4'd7;  // product registered, kick divider
	localparam logic [3:0] ST_EDIV = 4'd8;  // scaling division
	localparam logic [3:0] ST_EOUT = 4'd9;  // result held until taken

	// configuration registers
	logic [CORPUS_W-1:0] corpus_q;
	logic [YR_W-1:0]     y_range_q;
	logic                normalize_q;

	logic [3:0]          state_q;
	logic [BIN_W-1:0]    bin_q;
	logic [NUM_BINS-1:0] seen_q;      // per-bin valid: an unset entry reads as zero
	logic [CNT_W-1:0]    hit_cnt_q;
	logic [CNT_W-1:0]    hit_idx_q;
	logic [CNT_W-1:0]    peak_q;
	logic                issue_q;
	logic                pk_rd_s1;
	logic [BIN_W-1:0]    pk_bin_s1;
	logic [48:0]         prod_q;

	// output register
	logic                out_valid_q;
	logic [CNT_W-1:0]    out_value_q;
	logic [CNT_W-1:0]    out_first_q;
	logic                out_fvalid_q;
	logic                out_last_q;
	logic [BIN_W-1:0]    out_bin_q;

	// store and divider
	logic                ram_we;
	bin_entry_t          ram_wdata;
	logic [ENTRY_W-1:0]  ram_rdata;
	bin_entry_t          rd_ent;
	div_req_t            div_req;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_NUM_W-1:0] div_den;
	logic                div_done;
	logic [DIV_Q_W-1:0]  div_quot;

	logic                s_acc;
	logic                hit_acc;
	logic                pos_neg;
	logic                pos_over;
	logic                cur_seen;
	logic                pk_seen;
	logic [CNT_W-1:0]    cur_cnt;
	logic [CNT_W-1:0]    pk_cand;
	logic [YR_W-1:0]     y_m1;
	logic                scale_ok;
	logic [DIV_NUM_W-1:0] bin_num;
	logic [DIV_NUM_W-1:0] bin_den;
	logic [DIV_NUM_W-1:0] scl_num;
	logic [DIV_NUM_W-1:0] scl_den;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign hit_acc  = s_acc && (s_tuser == KIND_HIT);
	assign pos_neg  = s_tdata[POS_W-1];
	assign pos_over = (s_tdata[CORPUS_W-1:0] > corpus_q);

	assign rd_ent   = ram_rdata;
	assign cur_seen = seen_q[bin_q];
	assign cur_cnt  = cur_seen ? rd_ent.count : '0;
	assign pk_seen  = seen_q[pk_bin_s1];
	assign pk_cand  = pk_seen ? rd_ent.count : '0;

	assign y_m1     = y_range_q - YR_W'(1);
	assign scale_ok = (peak_q != '0) && (y_range_q != '0);

	// bin = floor(pos * NUM_BINS / (corpus_size + 1)); pos <= corpus keeps it below NUM_BINS
	assign bin_num = DIV_NUM_W'(s_tdata[CORPUS_W-1:0]) * DIV_NUM_W'(NUM_BINS);
	assign bin_den = DIV_NUM_W'({1'b0, corpus_q} + 32'd1) << (BIN_W - 1);
	// scaled = floor((2*count*(y-1) + peak) / (2*peak)), 17 quotient bits
	assign scl_num = {prod_q, 1'b0} + DIV_NUM_W'(peak_q);
	assign scl_den = DIV_NUM_W'(peak_q) << (DIV_Q_W);

	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = DIV_STEP_W'(BIN_W);
		div_num       = bin_num;
		div_den       = bin_den;
		if (state_q == ST_EMUL) begin
			div_req.start = 1'b1;
			div_req.steps = SCALE_STEPS;
			div_num       = scl_num;
			div_den       = scl_den;
		end else if (hit_acc && !pos_neg && !pos_over) begin
			div_req.start = 1'b1;
		end
	end

	// read-modify-write of the hit bin, saturating count
	assign ram_we          = (state_q == ST_BUPD);
	assign ram_wdata.count = (cur_cnt != '1) ? cur_cnt + CNT_W'(1) : cur_cnt;
	assign ram_wdata.first = cur_seen ? rd_ent.first : hit_idx_q;

	phn_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_BINS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (bin_q),
		.wdata (ram_wdata),
		.raddr (bin_q),
		.rdata (ram_rdata)
	);

	phn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den_sh (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corpus_q    <= CORPUS_RST;
			y_range_q   <= Y_RANGE_RST;
			normalize_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CORPUS_SIZE: corpus_q    <= cfg_data;
				CFG_Y_RANGE:     y_range_q   <= cfg_data[YR_W-1:0];
				CFG_NORMALIZE:   normalize_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bin_q       <= '0;
			seen_q      <= '0;
			hit_cnt_q   <= '0;
			issue_q     <= 1'b0;
			pk_rd_s1    <= 1'b0;
			pk_bin_s1   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == KIND_FINISH) begin
							bin_q   <= '0;
							issue_q <= 1'b1;
							state_q <= ST_PEAK;
						end else begin
							// every hit advances the index, empty ones too
							if (hit_cnt_q != '1) begin
								hit_cnt_q <= hit_cnt_q + CNT_W'(1);
							end
							if (pos_neg) begin
								state_q <= ST_IDLE;
							end else if (pos_over) begin
								bin_q   <= LAST_BIN;
								state_q <= ST_BRD;
							end else begin
								state_q <= ST_BDIV;
							end
						end
					end
				end
				ST_BDIV: begin
					if (div_done) begin
						bin_q   <= div_quot[BIN_W-1:0];
						state_q <= ST_BRD;
					end
				end
				ST_BRD: begin
					state_q <= ST_BUPD;
				end
				ST_BUPD: begin
					seen_q[bin_q] <= 1'b1;
					state_q       <= ST_IDLE;
				end
				ST_PEAK: begin
					// one read issued per cycle, data lines up with pk_rd_s1
					pk_rd_s1  <= issue_q;
					pk_bin_s1 <= bin_q;
					if (issue_q) begin
						if (bin_q == LAST_BIN) begin
							issue_q <= 1'b0;
							bin_q   <= '0;
						end else begin
							bin_q <= bin_q + BIN_W'(1);
						end
					end else if (!pk_rd_s1) begin
						state_q <= ST_ERD;
					end
				end
				ST_ERD: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (normalize_q && scale_ok) begin
						state_q <= ST_EMUL;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= ST_EOUT;
					end
				end
				ST_EMUL: begin
					state_q <= ST_EDIV;
				end
				ST_EDIV: begin
					if (div_done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_EOUT;
					end
				end
				ST_EOUT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (bin_q == LAST_BIN) begin
							// end of run: drop all bins and the hit index
							seen_q    <= '0;
							hit_cnt_q <= '0;
							bin_q     <= '0;
							state_q   <= ST_IDLE;
						end else begin
							bin_q   <= bin_q + BIN_W'(1);
							state_q <= ST_ERD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (hit_acc) begin
			hit_idx_q <= hit_cnt_q;
		end
		if (s_acc && (s_tuser == KIND_FINISH)) begin
			peak_q <= '0;
		end else if ((state_q == ST_PEAK) && pk_rd_s1 && (pk_cand > peak_q)) begin
			peak_q <= pk_cand;
		end
		if (state_q == ST_EVAL) begin
			prod_q       <= 49'(cur_cnt) * 49'(y_m1);
			out_value_q  <= normalize_q ? '0 : cur_cnt;
			out_first_q  <= cur_seen ? rd_ent.first : '0;
			out_fvalid_q <= cur_seen;
			out_last_q   <= (bin_q == LAST_BIN);
			out_bin_q    <= bin_q;
		end
		if ((state_q == ST_EDIV) && div_done) begin
			out_value_q <= CNT_W'(div_quot);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, peak_q, out_fvalid_q, out_first_q, out_value_q,
		BIN_OUT_W'(out_bin_q)};

endmodule

`default_nettype wire

/* rtl/phn_chk.sv */
// Port-level checker for the position histogram normalizer, bound to the top level.
// Depends on phn_pkg and position_histogram_normalizer_macros.svh.
`default_nettype none

`include "position_histogram_normalizer_macros.svh"

module phn_chk
	import phn_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [M_DATA_W-1:0]   m_tdata,
	input wire logic                  m_tlast
);

	logic last_bin;
	logic unset_clean;

	assign last_bin    = (m_tdata[5:0] == BIN_OUT_W'(NUM_BINS - 1));
	assign unset_clean = m_tdata[70] || (m_tdata[69:38] == '0);

	`PHN_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
	`PHN_ASSERT_NOW(a_no_accept, m_tvalid, !s_tready, "input taken while a result is pending")
	`PHN_ASSERT_NOW(a_last, m_tvalid, m_tlast == last_bin, "tlast not on the final bin")
	`PHN_ASSERT_NOW(a_unset, m_tvalid, unset_clean, "first_hit set on an empty bin")
	`PHN_ASSERT_NEXT(a_back_idle, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid, "not idle after the final bin")

endmodule

bind position_histogram_normalizer phn_chk #(.NUM_BINS(NUM_BINS)) u_phn_chk (.*);

`default_nettype wire

/* dv/position_histogram_normalizer_test.sv */
// Self-checking testbench for position_histogram_normalizer: hit streams, finish passes,
// register settings and back-pressure, checked against an in-bench histogram predictor.
// Depends on phn_pkg and the RTL of the block; needs nothing else.
`default_nettype none

module position_histogram_normalizer_test;
	import phn_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BINS          = NUM_BINS_DEF;
	localparam int IDLE_LIMIT    = 5000;  // cycles without any transaction before giving up
	localparam int RANDOM_ITEMS  = 444;
	localparam int HOLD_CYCLES   = 400;   // long receiver hold-off, fills the block
	localparam int SETTLE_CYCLES = 40;    // margin before a cfg write, lets a hit in flight finish

	// one input transaction
	typedef struct packed {
		logic        kind;
		logic [31:0] position;
	} hit_item_t;

	// one bin result as it leaves the block
	typedef struct packed {
		logic [5:0]  bin_index;
		logic [31:0] bin_value;
		logic [31:0] first_hit;
		logic        first_valid;
		logic [31:0] peak_count;
		logic        last;
	} bin_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;   // [31:0] position
	logic                  s_tuser = KIND_HIT; // [0] kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;        // [5:0] bin_index, [37:6] bin_value,
	                                       // [69:38] first_hit, [70] first_valid,
	                                       // [102:71] peak_count, [103] zero
	logic                  m_tlast;        // last
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_CORPUS_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	position_histogram_normalizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Histogram predictor: own copy of registers and per-bin stores
	// ------------------------------------------------------------------
	logic [CORPUS_W-1:0] cfg_corpus = CORPUS_RST;
	logic [YR_W-1:0]     cfg_yrange = Y_RANGE_RST;
	logic                cfg_norm   = 1'b0;

	logic [31:0] bin_cnt   [BINS];
	logic [31:0] bin_first [BINS];
	logic        bin_seen  [BINS];
	logic [31:0] hit_idx;

	bin_result_t bin_results_q[$];   // bin results still owed by the block
	hit_item_t   pend_q[$];          // transactions not yet offered

	int n_errors   = 0;
	int n_items    = 0;
	int n_finishes = 0;
	int n_results  = 0;
	int n_settings = 0;

	initial begin
		for (int b = 0; b < BINS; b++) begin
			bin_cnt[b]   = '0;
			bin_first[b] = '0;
			bin_seen[b]  = 1'b0;
		end
		hit_idx = '0;
	end

	// floor(pos * BINS / (corpus + 1)), clamped to the top bin
	function automatic int bin_of(logic [31:0] pos);
		logic [63:0] q;
		q = ({32'd0, pos} * 64'(BINS)) / ({33'd0, cfg_corpus} + 64'd1);
		if (q >= 64'(BINS))
			return BINS - 1;
		return int'(q);
	endfunction

	// count * (y_range - 1) / peak, rounded half up; zero peak or zero range gives 0
	function automatic logic [31:0] scaled(logic [31:0] count, logic [31:0] peak);
		logic [63:0] num;
		logic [63:0] q;
		if (peak == '0 || cfg_yrange == '0)
			return '0;
		num = {32'd0, count} * ({47'd0, cfg_yrange} - 64'd1) * 64'd2 + {32'd0, peak};
		q = num / ({32'd0, peak} * 64'd2);
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	// fold one accepted transaction into the stores; a finish emits every bin and clears
	task automatic tally_item(hit_item_t it);
		logic [31:0] idx;
		logic [31:0] peak;
		bin_result_t r;
		int b;
		if (it.kind == KIND_HIT) begin
			idx = hit_idx;
			if (hit_idx != 32'hFFFF_FFFF)
				hit_idx++;
			// negative positions only advance the hit index
			if (!it.position[31]) begin
				b = bin_of(it.position);
				if (bin_cnt[b] != 32'hFFFF_FFFF)
					bin_cnt[b]++;
				if (!bin_seen[b]) begin
					bin_seen[b]  = 1'b1;
					bin_first[b] = idx;
				end
			end
		end else begin
			peak = '0;
			for (int i = 0; i < BINS; i++)
				if (bin_cnt[i] > peak)
					peak = bin_cnt[i];
			for (int i = 0; i < BINS; i++) begin
				r.bin_index   = 6'(i);
				r.bin_value   = cfg_norm ? scaled(bin_cnt[i], peak) : bin_cnt[i];
				r.first_hit   = bin_seen[i] ? bin_first[i] : 32'd0;
				r.first_valid = bin_seen[i];
				r.peak_count  = peak;
				r.last        = (i == BINS - 1);
				bin_results_q.insert(bin_results_q.size(), r);
			end
			for (int i = 0; i < BINS; i++) begin
				bin_cnt[i]   = '0;
				bin_first[i] = '0;
				bin_seen[i]  = 1'b0;
			end
			hit_idx = '0;
			n_finishes++;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of transactions from pend_q with random gaps between them
	// ------------------------------------------------------------------
	hit_item_t drv_item;
	int        burst_left = 0;
	int        gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= KIND_HIT;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				tally_item(drv_item);
				n_items++;
			end
			// slot free: either nothing offered or the offer was just taken
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					drv_item = pend_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= drv_item.position;
					s_tuser  <= drv_item.kind;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// now and then a long stretch with no gaps at all
						if ($urandom_range(0, 5) == 0) begin
							burst_left = $urandom_range(40, 120);
							gap_left   = 0;
						end else begin
							burst_left = $urandom_range(0, 15);
							gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
						end
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: receiver stall pattern, long hold-off, field checks
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;
	int hold_cnt   = 0;
	int n_holds    = 0;

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			n_errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bin_result_t exp_r;
		bin_result_t got;
		logic        rdy;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.bin_index   = m_tdata[5:0];
				got.bin_value   = m_tdata[37:6];
				got.first_hit   = m_tdata[69:38];
				got.first_valid = m_tdata[70];
				got.peak_count  = m_tdata[102:71];
				got.last        = m_tlast;
				n_results++;
				if (bin_results_q.size() == 0) begin
					$error("bin result with none expected: bin_index %0d", got.bin_index);
					n_errors++;
				end else begin
					exp_r = bin_results_q.pop_front();
					check_field("bin_index", 32'(exp_r.bin_index), 32'(got.bin_index));
					check_field("bin_value", exp_r.bin_value, got.bin_value);
					check_field("first_hit", exp_r.first_hit, got.first_hit);
					check_field("first_valid", 32'(exp_r.first_valid), 32'(got.first_valid));
					check_field("peak_count", exp_r.peak_count, got.peak_count);
					check_field("last", 32'(exp_r.last), 32'(got.last));
					check_field("pad", 32'd0, 32'(m_tdata[103]));
				end
			end

			// long hold-off while the sender keeps offering, so the input stalls
			if (hold_cnt == 0 && n_holds < 2 && n_results > 150 && s_tvalid && m_tvalid) begin
				hold_cnt = HOLD_CYCLES;
				n_holds++;
			end

			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 200);
			end
			stall_left--;
			stall_tick++;
			if (hold_cnt > 0) begin
				hold_cnt--;
				rdy = 1'b0;
			end else begin
				case (stall_mode)
					0:       rdy = 1'b1;
					1:       rdy = $urandom_range(0, 1);
					2:       rdy = (stall_tick % 4 == 0);
					default: rdy = ($urandom_range(0, 7) != 0);
				endcase
			end
			m_tready <= rdy;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: no transaction on any port for too long ends the run
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: %0d cycles without a transaction, %0d results owed",
					idle_cycles, bin_results_q.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CORPUS_SIZE: cfg_corpus = val[CORPUS_W-1:0];
			CFG_Y_RANGE:     cfg_yrange = val[YR_W-1:0];
			CFG_NORMALIZE:   cfg_norm   = val[0];
			default: ;
		endcase
	endtask

	// sender pauses until every owed result is back, then lets a hit finish inside
	task automatic wait_drained();
		while (pend_q.size() != 0 || s_tvalid || bin_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic new_setting(logic [30:0] corpus, logic [16:0] yr, logic norm);
		wait_drained();
		write_reg(CFG_CORPUS_SIZE, corpus);
		write_reg(CFG_Y_RANGE, 31'(yr));
		write_reg(CFG_NORMALIZE, 31'(norm));
		n_settings++;
	endtask

	task automatic push_hit(logic [31:0] pos);
		hit_item_t it;
		it.kind     = KIND_HIT;
		it.position = pos;
		pend_q.insert(pend_q.size(), it);
	endtask

	task automatic push_finish(logic [31:0] pos);
		hit_item_t it;
		it.kind     = KIND_FINISH;
		it.position = pos;
		pend_q.insert(pend_q.size(), it);
	endtask

	// mostly in-corpus positions, with repeats to grow counts, beyond-corpus and negatives
	function automatic logic [31:0] pick_position(logic [30:0] corpus, logic [31:0] prev);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom_range(32'(corpus), 0);
			5:             return prev;
			6:             return 32'(corpus) + 32'd1 + $urandom_range(0, 1000);
			7:             return $urandom;
			8:             return 32'hFFFF_FFFF;
			default:       return $urandom | 32'h8000_0000;
		endcase
	endfunction

	initial begin
		logic [30:0] corpus;
		logic [16:0] yr;
		logic        norm;
		logic [31:0] pos;
		int          rand_sent;
		int          runs;
		int          hits;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: corpus 1 puts 0 in bin 0, 1 in bin 32, anything larger in the top bin
		push_hit(32'd0);
		push_hit(32'd1);
		push_hit(32'd0);
		push_hit(32'd2);
		push_hit(32'h7FFF_FFFF);
		push_hit(32'hFFFF_FFFF);       // empty hit
		push_hit(32'h8000_0000);       // other negative position
		push_hit(32'd1);
		push_finish(32'hDEAD_BEEF);    // position ignored on finish
		push_finish(32'hFFFF_FFFF);    // empty histogram right after a clear

		// zero corpus, zero range: zero peak first, then hits with no scale
		new_setting(31'd0, 17'd0, 1'b1);
		push_finish(32'd0);
		push_hit(32'd0);
		push_hit(32'd5);
		push_hit(32'd0);
		push_finish(32'h7FFF_FFFF);

		// widest corpus and a scale of 65536 levels
		new_setting(31'h7FFF_FFFF, 17'd65536, 1'b1);
		push_hit(32'h7FFF_FFFF);
		push_hit(32'h4000_0000);
		push_hit(32'h3FFF_FFFF);
		push_hit(32'h4000_0000);
		push_hit(32'h5555_5555);
		push_hit(32'h2AAA_AAAA);
		push_finish(32'd0);

		// single-level scale: every scaled count rounds to zero
		new_setting(31'd63, 17'd1, 1'b1);
		push_hit(32'd10);
		push_hit(32'd63);
		push_hit(32'd64);
		push_finish(32'd0);

		// random settings, each a few runs of hits closed by a finish
		rand_sent = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 7))
				0:       corpus = 31'd0;
				1:       corpus = 31'd1;
				2:       corpus = 31'd63;
				3:       corpus = 31'($urandom_range(64, 200));
				4:       corpus = 31'($urandom_range(1, 100000));
				5:       corpus = 31'($urandom);
				6:       corpus = 31'h7FFF_FFFF;
				default: corpus = 31'($urandom_range(1000, 4000));
			endcase
			case ($urandom_range(0, 7))
				0:       yr = 17'd1;
				1:       yr = 17'd2;
				2:       yr = 17'd3;
				3:       yr = 17'd256;
				4:       yr = 17'd65536;
				5:       yr = 17'd65535;
				default: yr = 17'($urandom_range(1, 65536));
			endcase
			norm = ($urandom_range(0, 2) != 0);
			new_setting(corpus, yr, norm);

			runs = $urandom_range(1, 4);
			pos  = '0;
			for (int r = 0; r < runs; r++) begin
				hits = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
				                                   : $urandom_range(0, 25);
				for (int h = 0; h < hits; h++) begin
					pos = pick_position(corpus, pos);
					push_hit(pos);
				end
				push_finish($urandom);
				rand_sent += hits + 1;
			end
		end

		wait_drained();
		repeat (200) @(posedge clk);

		$display("ran %0d transactions (%0d finishes) over %0d register settings,",
			n_items, n_finishes, n_settings + 1);
		$display("checked %0d bin results with %0d receiver hold-offs", n_results, n_holds);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
